FILE: rtl/jfx_pkg.sv
`default_nettype none

package jfx_pkg;

    // Ring depth default
    localparam int RING_DEPTH_DEFAULT = 4096;

    // Sample format (Q1.15)
    localparam int SAMPLE_W = 16;

    // Fade length is a power of two, so the fade divide is an arithmetic shift
    localparam int FADE_LENGTH = 256;
    localparam int FADE_SHIFT  = $clog2(FADE_LENGTH);
    localparam int NUM_W       = FADE_SHIFT + 1;

    // Read request limits
    localparam int MAX_READ = 64;
    localparam int CNT_W    = $clog2(MAX_READ + 1);
    localparam int IDX_W    = $clog2(MAX_READ);

    // Field widths
    localparam int KIND_W   = 1;
    localparam int THR_W    = 12;
    localparam int FILL_W   = 12;
    localparam int UNDER_W  = 16;
    localparam int STATUS_W = 3;

    // Stream packing
    localparam int S_FIELDS_W = SAMPLE_W + CNT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = SAMPLE_W + FILL_W + UNDER_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_WATER_MARK  = 2'd2;

    localparam logic [THR_W-1:0] START_THRESHOLD_RESET = 12'd2048;
    localparam logic [THR_W-1:0] LOW_WATER_MARK_RESET  = 12'd512;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_READ  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_WRITTEN   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PLAYED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WAITING   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNDERRUN  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FADE_CONT = 3'd5;

    // Request to the shared fade unit
    typedef struct packed {
        logic                en;
        logic [SAMPLE_W-1:0] sample;
        logic [NUM_W-1:0]    num;
    } fade_req_t;

endpackage

`default_nettype wire

FILE: rtl/jfx_ring.sv
`default_nettype none

module jfx_ring #(
    parameter int DEPTH  = jfx_pkg::RING_DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [ADDR_W-1:0]            wr_addr,
    input  wire logic [jfx_pkg::SAMPLE_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]            rd_addr,
    output logic      [jfx_pkg::SAMPLE_W-1:0] rd_data
);
    import jfx_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];

    // Write one sample
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/jfx_fade.sv
`default_nettype none

// Shared scaling unit: q = trunc(sample * num / FADE_LENGTH), toward zero
module jfx_fade (
    input  wire logic                         aclk,
    input  wire jfx_pkg::fade_req_t           req,
    output logic      [jfx_pkg::SAMPLE_W-1:0] q
);
    import jfx_pkg::*;

    localparam int PROD_W = SAMPLE_W + NUM_W + 1;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] shifted;

    // Multiply, round negative products toward zero, then shift down
    assign prod    = $signed(req.sample) * $signed({1'b0, req.num});
    assign bias    = prod[PROD_W-1] ? $signed(PROD_W'(FADE_LENGTH - 1)) : '0;
    assign adj     = prod + bias;
    assign shifted = adj >>> FADE_SHIFT;

    // Hold result until the next request
    always_ff @(posedge aclk) begin
        if (req.en) begin
            q <= shifted[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/jitter_fifo_with_crossfade_top.sv
`default_nettype none

// Write item: accepted when idle, its single result is offered on the next cycle.
// Read item of N samples: a decision state, then for each result a ring read (S_FETCH),
// the shared fade multiply (S_SCALE) and a present state (S_EMIT) that a stalling sink holds.
// One ring read port and one shared fade multiplier serialize them; new items wait for idle.
// Reset (aresetn low, synchronous) clears pointers, fade state, counters and the held sample,
// and loads config defaults; the ring is not swept, since only entries inside the fill are used.
module jitter_fifo_with_crossfade_top #(
    parameter int RING_DEPTH = jfx_pkg::RING_DEPTH_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input item
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [jfx_pkg::S_TDATA_W-1:0]  s_tdata,  // sample_in, read_count, zero pad
    input  wire logic [jfx_pkg::KIND_W-1:0]     s_tuser,  // kind
    // result item
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [jfx_pkg::M_TDATA_W-1:0]  m_tdata,  // sample_out, fill_level, underruns, pad
    output logic                                m_tlast,
    output logic      [jfx_pkg::STATUS_W-1:0]   m_tuser,  // status
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [jfx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [jfx_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jfx_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int EXT_W = PTR_W + 1;
    localparam int CMP_W = (PTR_W > THR_W) ? PTR_W : THR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_FETCH,
        S_SCALE,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_WRITE,
        MODE_SILENCE,
        MODE_FADE,
        MODE_PLAY
    } mode_t;

    // Configuration
    logic             jit_reg;
    logic [THR_W-1:0] thr_reg;
    logic [THR_W-1:0] lwm_reg;

    // Persistent state
    state_t              state_reg;
    logic [PTR_W-1:0]    wp_reg;
    logic [PTR_W-1:0]    rp_reg;
    logic                primed_reg;
    logic [NUM_W-1:0]    fade_left_reg;
    logic                fading_in_reg;
    logic [SAMPLE_W-1:0] held_reg;
    logic [UNDER_W-1:0]  under_reg;

    // Per-item working registers
    mode_t               mode_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    req_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    take_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [FILL_W-1:0]   fill_out_reg;

    // Input fields
    logic [SAMPLE_W-1:0] in_sample;
    logic [CNT_W-1:0]    in_count;
    logic [CNT_W-1:0]    in_count_sat;
    logic                in_acc;
    logic                wr_acc;
    logic                rd_acc;

    logic [PTR_W-1:0]    fill_c;
    logic                full_c;
    logic [PTR_W-1:0]    wp_inc;
    logic [PTR_W-1:0]    rp_inc;
    logic                last_c;
    logic                in_fade;
    logic                in_take;

    // Decision results
    mode_t               d_mode;
    logic [STATUS_W-1:0] d_status;
    logic                d_primed;
    logic [NUM_W-1:0]    d_fade_left;
    logic                d_fading_in;
    logic [UNDER_W-1:0]  d_under;
    logic [CNT_W-1:0]    d_n;
    logic [CNT_W-1:0]    d_take;
    logic [NUM_W-1:0]    d_num;
    logic [FILL_W-1:0]   d_fill_out;
    logic                d_go_play;

    fade_req_t           fade_req;
    logic [SAMPLE_W-1:0] fade_q;
    logic [SAMPLE_W-1:0] ring_q;

    // Unpack input item
    assign in_sample    = s_tdata[SAMPLE_W-1:0];
    assign in_count     = s_tdata[SAMPLE_W +: CNT_W];
    assign in_count_sat = (in_count > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : in_count;
    assign in_acc       = s_tvalid && s_tready;
    assign wr_acc       = in_acc && (s_tuser == KIND_WRITE);
    assign rd_acc       = in_acc && (s_tuser == KIND_READ);

    // Fill level and pointer wrap
    assign fill_c = (wp_reg >= rp_reg) ? (wp_reg - rp_reg)
                  : PTR_W'(EXT_W'(wp_reg) + EXT_W'(RING_DEPTH) - EXT_W'(rp_reg));
    assign full_c = (fill_c == PTR_W'(RING_DEPTH - 1));
    assign wp_inc = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_reg + 1'b1;

    assign last_c  = (CNT_W'(idx_reg) == req_reg - CNT_W'(1));
    assign in_fade = (CNT_W'(idx_reg) < n_reg);
    assign in_take = (CNT_W'(idx_reg) < take_reg);

    // Decide what a read item does
    always_comb begin
        d_mode      = MODE_PLAY;
        d_status    = ST_PLAYED;
        d_primed    = primed_reg;
        d_fade_left = fade_left_reg;
        d_fading_in = fading_in_reg;
        d_under     = under_reg;
        d_n         = '0;
        d_take      = '0;
        d_num       = NUM_W'(FADE_LENGTH);
        d_fill_out  = FILL_W'(fill_c);
        d_go_play   = 1'b1;

        if (jit_reg && !primed_reg) begin
            if (!fading_in_reg && fade_left_reg != '0) begin
                // continue a pending fade-out
                d_mode      = MODE_FADE;
                d_status    = ST_FADE_CONT;
                d_n         = (CMP_W'(req_reg) < CMP_W'(fade_left_reg)) ? req_reg
                            : CNT_W'(fade_left_reg);
                d_num       = fade_left_reg;
                d_fade_left = fade_left_reg - NUM_W'(d_n);
                d_go_play   = 1'b0;
            end else if (CMP_W'(fill_c) >= CMP_W'(thr_reg)) begin
                // start playback with a fade-in
                d_primed    = 1'b1;
                d_fade_left = NUM_W'(FADE_LENGTH);
                d_fading_in = 1'b1;
            end else begin
                d_mode    = MODE_SILENCE;
                d_status  = ST_WAITING;
                d_go_play = 1'b0;
            end
        end

        if (d_go_play) begin
            if (jit_reg && CMP_W'(fill_c) < CMP_W'(lwm_reg)
                    && CMP_W'(fill_c) < CMP_W'(req_reg)) begin
                // underrun: pause and fade out from the held sample
                d_under     = under_reg + 1'b1;
                d_primed    = 1'b0;
                d_fading_in = 1'b0;
                d_mode      = MODE_FADE;
                d_status    = ST_UNDERRUN;
                d_n         = (CMP_W'(req_reg) < CMP_W'(FADE_LENGTH)) ? req_reg
                            : CNT_W'(FADE_LENGTH);
                d_num       = NUM_W'(FADE_LENGTH);
                d_fade_left = NUM_W'(FADE_LENGTH) - NUM_W'(d_n);
            end else begin
                d_take = (CMP_W'(req_reg) < CMP_W'(fill_c)) ? req_reg : CNT_W'(fill_c);
                if (d_fading_in && d_fade_left != '0) begin
                    d_n = (CMP_W'(d_take) < CMP_W'(d_fade_left)) ? d_take
                        : CNT_W'(d_fade_left);
                    d_num       = NUM_W'(FADE_LENGTH) - d_fade_left + NUM_W'(1);
                    d_fade_left = d_fade_left - NUM_W'(d_n);
                    if (d_fade_left == '0) begin
                        d_fading_in = 1'b0;
                    end
                end
                d_fill_out = FILL_W'(fill_c - PTR_W'(d_take));
            end
        end
    end

    // Feed the shared fade unit
    always_comb begin
        fade_req.en     = wr_acc || (state_reg == S_SCALE);
        fade_req.sample = '0;
        fade_req.num    = NUM_W'(FADE_LENGTH);
        if (state_reg == S_SCALE) begin
            case (mode_reg)
                MODE_FADE: begin
                    if (in_fade) begin
                        fade_req.sample = held_reg;
                        fade_req.num    = num_reg;
                    end
                end
                MODE_PLAY: begin
                    if (in_take) begin
                        fade_req.sample = ring_q;
                        if (in_fade) begin
                            fade_req.num = num_reg;
                        end
                    end
                end
                default: begin
                    fade_req.sample = '0;
                end
            endcase
        end
    end

    jfx_ring #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_acc && !full_c),
        .wr_addr (wp_reg),
        .wr_data (in_sample),
        .rd_addr (rp_reg),
        .rd_data (ring_q)
    );

    jfx_fade u_fade (
        .aclk (aclk),
        .req  (fade_req),
        .q    (fade_q)
    );

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            primed_reg    <= 1'b0;
            fade_left_reg <= '0;
            fading_in_reg <= 1'b0;
            held_reg      <= '0;
            under_reg     <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (wr_acc) begin
                        // store or drop, one result follows
                        mode_reg     <= MODE_WRITE;
                        req_reg      <= CNT_W'(1);
                        idx_reg      <= '0;
                        status_reg   <= full_c ? ST_DROPPED : ST_WRITTEN;
                        fill_out_reg <= full_c ? FILL_W'(fill_c) : FILL_W'(fill_c + 1'b1);
                        if (!full_c) begin
                            wp_reg <= wp_inc;
                        end
                        state_reg <= S_EMIT;
                    end else if (rd_acc && in_count != '0) begin
                        req_reg   <= in_count_sat;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    mode_reg      <= d_mode;
                    status_reg    <= d_status;
                    primed_reg    <= d_primed;
                    fade_left_reg <= d_fade_left;
                    fading_in_reg <= d_fading_in;
                    under_reg     <= d_under;
                    n_reg         <= d_n;
                    take_reg      <= d_take;
                    num_reg       <= d_num;
                    fill_out_reg  <= d_fill_out;
                    idx_reg       <= '0;
                    state_reg     <= S_FETCH;
                end
                S_FETCH: begin
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    // advance read pointer and fade step
                    if (mode_reg == MODE_PLAY && in_take) begin
                        rp_reg <= rp_inc;
                    end
                    if (mode_reg == MODE_FADE) begin
                        num_reg <= num_reg - NUM_W'(1);
                    end else begin
                        num_reg <= num_reg + NUM_W'(1);
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (m_tready) begin
                        if (mode_reg == MODE_PLAY && in_take) begin
                            held_reg <= fade_q;
                        end
                        if (last_c) begin
                            if (mode_reg == MODE_FADE && fade_left_reg == '0) begin
                                held_reg <= '0;
                            end
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_FETCH;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jit_reg <= 1'b1;
            thr_reg <= START_THRESHOLD_RESET;
            lwm_reg <= LOW_WATER_MARK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_JITTER_ENABLE:   jit_reg <= cfg_data[0];
                CFG_START_THRESHOLD: thr_reg <= cfg_data;
                CFG_LOW_WATER_MARK:  lwm_reg <= cfg_data;
                default: begin
                    jit_reg <= jit_reg;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_EMIT);
    assign m_tlast   = last_c;
    assign m_tuser   = status_reg;
    assign m_tdata   = {{M_PAD_W{1'b0}}, under_reg, fill_out_reg, fade_q};

endmodule

`default_nettype wire

FILE: rtl/jfx_chk.sv
`default_nettype none

module jfx_chk (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [jfx_pkg::KIND_W-1:0]     s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [jfx_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                           m_tlast,
    input wire logic [jfx_pkg::STATUS_W-1:0]   m_tuser
);
    import jfx_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // No new item is taken while a result is offered
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // A write item gives one final result, written or dropped, on the next cycle
    a_write_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_WRITE) |=>
            m_tvalid && m_tlast && (m_tuser == ST_WRITTEN || m_tuser == ST_DROPPED))
        else $error("write item without its single result");

    // Write results and waiting silence carry a zero sample
    a_zero_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_WRITTEN || m_tuser == ST_DROPPED
            || m_tuser == ST_WAITING) |-> (m_tdata[SAMPLE_W-1:0] == '0))
        else $error("nonzero sample on a silent result");

endmodule

bind jitter_fifo_with_crossfade_top jfx_chk u_jfx_chk (.*);

`default_nettype wire

FILE: verif/jfx_checker.sv
`timescale 1ns / 100ps

// Watches the input, result and configuration channels, predicts every result of the
// jitter FIFO and compares each accepted result against the oldest prediction.
module jfx_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [jfx_pkg::S_TDATA_W-1:0]  s_tdata,  // sample_in, read_count, zero pad
    input  wire logic [jfx_pkg::KIND_W-1:0]     s_tuser,  // kind
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [jfx_pkg::M_TDATA_W-1:0]  m_tdata,  // sample_out, fill_level, underruns, pad
    input  wire logic                           m_tlast,
    input  wire logic [jfx_pkg::STATUS_W-1:0]   m_tuser,  // status
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [jfx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [jfx_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                  outstanding,
    output int                                  mismatch_count
);
    import jfx_pkg::*;

    localparam int RING = RING_DEPTH_DEFAULT;

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       last;
        logic [STATUS_W-1:0]        status;
        logic [FILL_W-1:0]          fill;
        logic [UNDER_W-1:0]         unders;
    } played_t;

    played_t due_results[$];
    played_t want;

    // Shadow of the buffer state and registers
    logic signed [SAMPLE_W-1:0] ring [RING];
    logic [FILL_W-1:0]          wr_ptr;
    logic [FILL_W-1:0]          rd_ptr;
    logic                       primed;
    logic                       fading_in;
    int                         fade_left;
    logic signed [SAMPLE_W-1:0] held;
    logic [UNDER_W-1:0]         under_cnt;
    logic                       jit_en;
    logic [THR_W-1:0]           start_thr;
    logic [THR_W-1:0]           low_wm;

    // Samples of the read being predicted
    logic signed [SAMPLE_W-1:0] burst [MAX_READ];

    function automatic logic [FILL_W-1:0] ring_fill();
        return wr_ptr - rd_ptr;
    endfunction

    // Exact product, divide truncates toward zero
    function automatic logic signed [SAMPLE_W-1:0] fade_scale(
        input logic signed [SAMPLE_W-1:0] s,
        input int num
    );
        int prod;
        prod = int'(s) * num;
        return SAMPLE_W'(prod / FADE_LENGTH);
    endfunction

    // Fade the held sample down from step first_step, then pad with zeros
    task automatic fade_from_held(input int req, input int first_step);
        int n;
        n = (req < fade_left) ? req : fade_left;
        for (int i = 0; i < req; i++)
            burst[i] = (i < n) ? fade_scale(held, FADE_LENGTH - (first_step + i)) : '0;
        fade_left -= n;
        if (fade_left == 0)
            held = '0;
    endtask

    task automatic emit_burst(input int req, input logic [STATUS_W-1:0] st);
        played_t r;
        for (int i = 0; i < req; i++) begin
            r.smp    = burst[i];
            r.last   = (i == req - 1);
            r.status = st;
            r.fill   = ring_fill();
            r.unders = under_cnt;
            due_results.push_back(r);
        end
    endtask

    // Store one sample, or drop it when the ring is full
    task automatic predict_write(input logic signed [SAMPLE_W-1:0] smp);
        played_t r;
        r.smp  = '0;
        r.last = 1'b1;
        if (ring_fill() >= RING - 1) begin
            r.status = ST_DROPPED;
        end else begin
            ring[wr_ptr] = smp;
            wr_ptr++;
            r.status = ST_WRITTEN;
        end
        r.fill   = ring_fill();
        r.unders = under_cnt;
        due_results.push_back(r);
    endtask

    task automatic predict_read(input logic [CNT_W-1:0] cnt);
        int req;
        int fill;
        int take;
        int first_step;
        int n;
        logic [STATUS_W-1:0] st;
        logic done;
        req = cnt;
        if (req == 0)
            return;
        if (req > MAX_READ)
            req = MAX_READ;
        fill = ring_fill();
        done = 1'b0;
        st   = ST_PLAYED;

        // Paused: finish a pending fade-out, wait, or start playing
        if (jit_en && !primed) begin
            if (!fading_in && fade_left > 0) begin
                fade_from_held(req, FADE_LENGTH - fade_left);
                st   = ST_FADE_CONT;
                done = 1'b1;
            end else if (fill >= start_thr) begin
                primed    = 1'b1;
                fade_left = FADE_LENGTH;
                fading_in = 1'b1;
            end else begin
                for (int i = 0; i < req; i++)
                    burst[i] = '0;
                st   = ST_WAITING;
                done = 1'b1;
            end
        end

        // Underrun: count, pause and fade out from the last played sample
        if (!done && jit_en && fill < low_wm && fill < req) begin
            under_cnt++;
            primed    = 1'b0;
            fade_left = FADE_LENGTH;
            fading_in = 1'b0;
            fade_from_held(req, 0);
            st   = ST_UNDERRUN;
            done = 1'b1;
        end

        // Play stored samples, apply any pending fade-in, pad a short read
        if (!done) begin
            take = (req < fill) ? req : fill;
            for (int i = 0; i < take; i++) begin
                burst[i] = ring[rd_ptr];
                rd_ptr++;
            end
            if (fading_in && fade_left > 0) begin
                first_step = FADE_LENGTH - fade_left;
                n = (take < fade_left) ? take : fade_left;
                for (int i = 0; i < n; i++)
                    burst[i] = fade_scale(burst[i], first_step + i + 1);
                fade_left -= n;
                if (fade_left == 0)
                    fading_in = 1'b0;
            end
            if (take > 0)
                held = burst[take - 1];
            for (int i = take; i < req; i++)
                burst[i] = '0;
            st = ST_PLAYED;
        end
        emit_burst(req, st);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RING; i++)
                ring[i] = '0;
            wr_ptr    = '0;
            rd_ptr    = '0;
            primed    = 1'b0;
            fading_in = 1'b0;
            fade_left = 0;
            held      = '0;
            under_cnt = '0;
            jit_en    = 1'b1;
            start_thr = START_THRESHOLD_RESET;
            low_wm    = LOW_WATER_MARK_RESET;
            due_results.delete();
            mismatch_count = 0;
        end else begin
            // Compare an accepted result with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: sample %0d last %0d status %0d",
                                 $signed(m_tdata[SAMPLE_W-1:0]), m_tlast, m_tuser);
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[SAMPLE_W-1:0] != want.smp || m_tlast != want.last ||
                        m_tuser != want.status ||
                        m_tdata[SAMPLE_W +: FILL_W] != want.fill ||
                        m_tdata[SAMPLE_W+FILL_W +: UNDER_W] != want.unders) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result mismatch: expected sample %0d last %0d status %0d",
                                      " fill %0d underruns %0d, got sample %0d last %0d",
                                      " status %0d fill %0d underruns %0d"},
                                     want.smp, want.last, want.status, want.fill, want.unders,
                                     $signed(m_tdata[SAMPLE_W-1:0]), m_tlast, m_tuser,
                                     m_tdata[SAMPLE_W +: FILL_W],
                                     m_tdata[SAMPLE_W+FILL_W +: UNDER_W]);
                    end
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_JITTER_ENABLE:   jit_en    = cfg_data[0];
                    CFG_START_THRESHOLD: start_thr = cfg_data[THR_W-1:0];
                    CFG_LOW_WATER_MARK:  low_wm    = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            // Predict the results of an accepted item
            if (s_tvalid && s_tready) begin
                if (s_tuser == KIND_WRITE)
                    predict_write(s_tdata[SAMPLE_W-1:0]);
                else
                    predict_read(s_tdata[SAMPLE_W +: CNT_W]);
            end
        end
        outstanding = due_results.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import jfx_pkg::*;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int SETTLE_CYCLES = 200;   // covers the decision and the fetch, scale and present states of a full read
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 252;
    localparam int FILL_WRITES   = 100;   // writes offered; the sink starts a long hold-off halfway through
    localparam int DRAIN_READS   = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int outstanding;
    int mismatch_count;
    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_requests;
    int holds_served;
    int cycle_count;

    jitter_fifo_with_crossfade_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    jfx_checker u_watch (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Abort a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Result sink: random stalls, plus a long hold-off on request
    initial begin
        m_tready     = 1'b0;
        holds_served = 0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_served) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_served++;
            end else begin
                m_tready = ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Offer one item and hold it until accepted
    task automatic push_item(
        input logic [KIND_W-1:0]   kind,
        input logic [SAMPLE_W-1:0] smp,
        input logic [CNT_W-1:0]    cnt
    );
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = S_TDATA_W'({cnt, smp});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_write(input logic [SAMPLE_W-1:0] smp);
        push_item(KIND_WRITE, smp, CNT_W'($urandom()));
    endtask

    task automatic send_read(input logic [CNT_W-1:0] cnt);
        push_item(KIND_READ, SAMPLE_W'($urandom()), cnt);
    endtask

    // Stop offering, wait for every predicted result, then wait SETTLE_CYCLES more
    task automatic drain_block();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] val
    );
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(input logic jit, input int start_lvl, input int low_lvl);
        write_reg(CFG_JITTER_ENABLE, CFG_DATA_W'(jit));
        write_reg(CFG_START_THRESHOLD, CFG_DATA_W'(start_lvl));
        write_reg(CFG_LOW_WATER_MARK, CFG_DATA_W'(low_lvl));
    endtask

    // Mostly writes, reads mostly short, a few oversized or empty requests
    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 72) begin
            if ($urandom_range(7) == 0)
                send_write($urandom_range(1) ? 16'h7FFF : 16'h8000);
            else
                send_write(SAMPLE_W'($urandom()));
        end else begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_read(CNT_W'($urandom_range(1, 12)));
            else if (pick < 92)
                send_read(CNT_W'($urandom_range(13, MAX_READ)));
            else if (pick < 97)
                send_read(CNT_W'($urandom_range(MAX_READ + 1, 127)));
            else
                send_read('0);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = KIND_WRITE;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_JITTER_ENABLE;
        cfg_data      = '0;
        hold_requests = 0;
        snd_idle_pct  = 11;
        rcv_idle_pct  = 74;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: empty ring waits in silence; an empty request does nothing
        send_read(7'd5);
        send_read(7'd0);
        drain_block();
        write_reg(CFG_START_THRESHOLD, 12'd3);
        write_reg(CFG_LOW_WATER_MARK, 12'd2);
        write_reg(CFG_UNUSED_INDEX, 12'hFFF);

        // Extreme samples, priming with fade-in, oversized and short reads
        send_write(16'h7FFF);
        send_write(16'h8000);
        send_write(16'h0000);
        send_write(16'hFFFF);
        send_write(16'h0001);
        send_write(16'h8000);
        send_read(7'd2);
        send_read(7'd100);
        // Underrun, then the fade-out continues across reads until silence
        send_read(7'd64);
        send_read(7'd127);
        send_read(7'd64);
        send_read(7'd64);
        send_read(7'd2);
        send_write(16'h7FFF);
        send_write(16'h8000);
        send_write(16'h1234);
        send_read(7'd1);
        // Plain FIFO keeps the fade-in that is still pending
        drain_block();
        write_reg(CFG_JITTER_ENABLE, 12'd0);
        send_read(7'd8);
        send_write(16'h7FFF);

        // Highest thresholds: underrun, then wait while writes back up behind a long stall
        drain_block();
        set_regs(1'b1, 4095, 4095);
        repeat (5) send_read(7'd64);
        for (int i = 0; i < FILL_WRITES; i++) begin
            if (i == FILL_WRITES / 2)
                hold_requests++;
            send_write(SAMPLE_W'($urandom()));
        end
        repeat (DRAIN_READS) send_read(7'd64);

        // Random traffic under three settings and three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            drain_block();
            case (ph)
                0: begin
                    snd_idle_pct = 11;
                    rcv_idle_pct = 74;
                    set_regs(1'b1, 10, 6);
                end
                1: begin
                    snd_idle_pct = 74;
                    rcv_idle_pct = 11;
                    set_regs(1'b0, 0, 0);
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    set_regs(1'b1, 0, 4095);
                end
            endcase
            for (int i = 0; i < RANDOM_ITEMS / 3; i++)
                random_item();
        end

        drain_block();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
